// ----- src/fifo_victim_cache_table_top_assert.svh -----
// Assertion macros for the checker of the victim cache table.
`ifndef FIFO_VICTIM_CACHE_TABLE_TOP_ASSERT_SVH
`define FIFO_VICTIM_CACHE_TABLE_TOP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define VCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define VCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/vct_pkg.sv -----
`default_nettype none

package vct_pkg;

    localparam int ENTRIES_DEF  = 4;
    localparam int TAG_BITS_DEF = 32;
    localparam int SET_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_LOOKUP     = 2'd0,
        ACT_INSERT     = 2'd1,
        ACT_RESTORE    = 2'd2,
        ACT_MARK_DIRTY = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] tag;
        logic [15:0] set_index;
        logic        dirty_in;
        logic [1:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] hit_index;
        logic       dirty_out;
        logic       evicted;
        logic       full_res;
    } rsp_t;

endpackage

`default_nettype wire

// ----- src/vct_table.sv -----
`default_nettype none

module vct_table #(
    parameter int ENTRIES  = 4,
    parameter int TAG_BITS = 32,
    parameter int SET_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          issue,
    input  wire vct_pkg::req_t req,
    output vct_pkg::rsp_t      rsp
);
    import vct_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] OLDEST_AGE = IDX_W'(ENTRIES - 1);

    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [IDX_W-1:0]    age_reg   [ENTRIES];
    logic [IDX_W-1:0]    age_next  [ENTRIES];
    logic [TAG_BITS-1:0] tag_reg   [ENTRIES];
    logic [SET_BITS-1:0] set_reg   [ENTRIES];
    logic [ENTRIES-1:0]  dirty_reg;
    logic [ENTRIES-1:0]  dirty_next;
    logic [ENTRIES-1:0]  write_en;

    logic [TAG_BITS-1:0] key_tag;
    logic [SET_BITS-1:0] key_set;

    logic [ENTRIES-1:0]  match;
    logic [ENTRIES-1:0]  hit_oh;
    logic [IDX_W-1:0]    hit_slot;
    logic [ENTRIES-1:0]  free_oh;
    logic [ENTRIES-1:0]  oldest_oh;
    logic [ENTRIES-1:0]  ins_oh;
    logic [ENTRIES-1:0]  rst_oh;
    logic [IDX_W-1:0]    gone_age;
    logic                full;
    logic                is_insert;
    logic                is_restore;
    logic                is_mark;
    logic                is_lookup;

    assign key_tag = TAG_BITS'(req.tag);
    assign key_set = SET_BITS'(req.set_index);

    assign full       = &valid_reg;
    assign is_lookup  = (req.action == ACT_LOOKUP);
    assign is_insert  = (req.action == ACT_INSERT);
    assign is_restore = (req.action == ACT_RESTORE);
    assign is_mark    = (req.action == ACT_MARK_DIRTY);

    // Per-entry compares; ages of valid entries are distinct, so the
    // oldest one of a full table is the one at age ENTRIES-1.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]     = valid_reg[i] && (tag_reg[i] == key_tag) && (set_reg[i] == key_set);
            oldest_oh[i] = valid_reg[i] && (age_reg[i] == OLDEST_AGE);
            rst_oh[i]    = valid_reg[i] && (int'(req.entry_index) == i);
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        logic hit_found;
        logic free_found;
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_oh     = '0;
        free_oh    = '0;
        hit_slot   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i] && !hit_found)
            begin
                hit_found = 1'b1;
                hit_oh[i] = 1'b1;
                hit_slot  = IDX_W'(i);
            end
            if (!valid_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_oh[i] = 1'b1;
            end
        end
    end

    assign ins_oh = full ? oldest_oh : free_oh;

    always_comb
    begin
        gone_age = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (rst_oh[i])
            begin
                gone_age = age_reg[i];
            end
        end
    end

    // Next state of the whole table for the current request.
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        write_en   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (is_insert)
            begin
                if (ins_oh[i])
                begin
                    valid_next[i] = 1'b1;
                    dirty_next[i] = req.dirty_in;
                    write_en[i]   = 1'b1;
                    age_next[i]   = '0;
                end
                else if (valid_reg[i])
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            else if (is_restore && (|rst_oh))
            begin
                if (rst_oh[i])
                begin
                    valid_next[i] = 1'b0;
                end
                else if (valid_reg[i] && (age_reg[i] > gone_age))
                begin
                    age_next[i] = age_reg[i] - 1'b1;
                end
            end
            else if (is_mark && hit_oh[i])
            begin
                dirty_next[i] = 1'b1;
            end
        end
    end

    always_comb
    begin
        rsp           = '0;
        rsp.full_res  = &valid_next;
        if (is_lookup || is_mark)
        begin
            rsp.hit       = |match;
            rsp.hit_index = 2'(hit_slot);
        end
        else if (is_insert)
        begin
            rsp.evicted   = full;
            rsp.dirty_out = full && (|(oldest_oh & dirty_reg));
        end
        else
        begin
            rsp.dirty_out = |(rst_oh & dirty_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (issue)
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            dirty_reg <= dirty_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (write_en[i])
                begin
                    tag_reg[i] <= key_tag;
                    set_reg[i] <= key_set;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/fifo_victim_cache_table_top.sv -----
`default_nettype none

// Fully associative victim table with FIFO replacement. Each request
// (lookup, insert, restore by slot, mark dirty) transfers into a request
// register, is resolved in one pass over all entries at once, and its
// response lands in a response register: one request per cycle sustained
// while the response is not stalled. A request passes the request register
// and then the response register before its response is valid; the
// single-pass compare/age logic over ENTRIES slots between them sets the
// path length. A stalled response holds in its register while the request
// register keeps its item; the request side stalls only when both registers
// hold an item and the response is stalled.
module fifo_victim_cache_table_top #(
    parameter int ENTRIES  = vct_pkg::ENTRIES_DEF,
    parameter int TAG_BITS = vct_pkg::TAG_BITS_DEF,
    parameter int SET_BITS = vct_pkg::SET_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire vct_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output vct_pkg::rsp_t      rsp
);
    import vct_pkg::*;

    logic req_valid_reg;
    req_t req_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic out_free;
    logic issue;
    logic accept;

    // The response slot can take a new result when empty or draining now.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign issue     = req_valid_reg && out_free;
    assign req_stall = req_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;

    // Table state advances only when a request leaves the request register.
    vct_table #(
        .ENTRIES  (ENTRIES),
        .TAG_BITS (TAG_BITS),
        .SET_BITS (SET_BITS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .req   (req_reg),
        .rsp   (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Hold the request while the response side is blocked.
            if (accept)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                req_valid_reg <= 1'b0;
            end
            // Advance the response on issue, drop it once transferred.
            if (issue)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (issue)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- src/vct_checker.sv -----
`default_nettype none

`include "fifo_victim_cache_table_top_assert.svh"

module vct_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire vct_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire vct_pkg::rsp_t rsp
);
    import vct_pkg::*;

    `VCT_ASSERT_ALWAYS(a_rsp_idle_in_reset, !rst_n |-> !rsp_valid, "response valid in reset")

    `VCT_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)), "stalled response changed")

    `VCT_ASSERT(a_hit_excl, (rsp_valid && rsp.hit) |-> (!rsp.evicted && !rsp.dirty_out), "hit with eviction fields")

    `VCT_ASSERT(a_evict_full, (rsp_valid && rsp.evicted) |-> rsp.full_res, "eviction from a table that is not full")

    `VCT_ASSERT(a_miss_index, (rsp_valid && !rsp.hit) |-> (rsp.hit_index == 2'd0), "miss with nonzero index")

endmodule

bind fifo_victim_cache_table_top vct_checker u_vct_checker (.*);

`default_nettype wire

// ----- tb/sv/fifo_victim_cache_table_top_tb.sv -----
`default_nettype none

module fifo_victim_cache_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vct_pkg::*;

    localparam int SLOTS      = ENTRIES_DEF;
    localparam int STALL_LIMIT = 2000;   // cycles with no transfer before giving up
    localparam int KEY_POOL   = 8;

    // Scoreboard: keeps a private copy of the victim table, works out the
    // response of every request that transfers in, and checks the responses
    // that transfer out against them in order.
    class victim_table_scoreboard;
        bit          slot_valid [SLOTS];
        logic [31:0] slot_tag   [SLOTS];
        logic [15:0] slot_set   [SLOTS];
        bit          slot_dirty [SLOTS];
        int          slot_age   [SLOTS];
        bit          table_full;
        rsp_t        expected_rsps [$];
        int          errors;
        int          requests;
        int          hits;
        int          evictions;
        int          restores;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_age[i]   = 0;
            end
            table_full = 1'b0;
            errors     = 0;
            requests   = 0;
            hits       = 0;
            evictions  = 0;
            restores   = 0;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        function void note_request(req_t r);
            rsp_t res;
            int   slot;
            bit   found;
            int   gone;
            res   = '0;
            slot  = 0;
            found = 1'b0;
            requests++;
            case (r.action)
                ACT_LOOKUP, ACT_MARK_DIRTY:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!found && slot_valid[i] && slot_tag[i] == r.tag
                            && slot_set[i] == r.set_index)
                        begin
                            found = 1'b1;
                            slot  = i;
                        end
                    if (found)
                    begin
                        res.hit       = 1'b1;
                        res.hit_index = slot[1:0];
                        hits++;
                        if (r.action == ACT_MARK_DIRTY)
                            slot_dirty[slot] = 1'b1;
                    end
                end
                ACT_INSERT:
                begin
                    if (table_full)
                    begin
                        // oldest live entry goes, lowest slot on a tie
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i] && (!found || slot_age[i] > slot_age[slot]))
                            begin
                                found = 1'b1;
                                slot  = i;
                            end
                        if (found)
                        begin
                            res.evicted   = 1'b1;
                            res.dirty_out = slot_dirty[slot];
                            evictions++;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (!found && !slot_valid[i])
                            begin
                                found = 1'b1;
                                slot  = i;
                            end
                    end
                    if (found)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i] && i != slot && slot_age[i] < 255)
                                slot_age[i]++;
                        slot_valid[slot] = 1'b1;
                        slot_tag[slot]   = r.tag;
                        slot_set[slot]   = r.set_index;
                        slot_dirty[slot] = r.dirty_in;
                        slot_age[slot]   = 0;
                    end
                end
                ACT_RESTORE:
                begin
                    slot = int'(r.entry_index);
                    if (slot < SLOTS && slot_valid[slot])
                    begin
                        gone             = slot_age[slot];
                        res.dirty_out    = slot_dirty[slot];
                        slot_valid[slot] = 1'b0;
                        restores++;
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_valid[i] && slot_age[i] > gone)
                                slot_age[i]--;
                    end
                end
                default: ;
            endcase
            table_full = 1'b1;
            for (int i = 0; i < SLOTS; i++)
                if (!slot_valid[i])
                    table_full = 1'b0;
            res.full_res = table_full;
            expected_rsps.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $error("response transfer with nothing outstanding: %p", got);
                errors++;
                return;
            end
            want = expected_rsps.pop_front();
            compare_field("hit",       int'(want.hit),       int'(got.hit));
            compare_field("hit_index", int'(want.hit_index), int'(got.hit_index));
            compare_field("dirty_out", int'(want.dirty_out), int'(got.dirty_out));
            compare_field("evicted",   int'(want.evicted),   int'(got.evicted));
            compare_field("full_res",  int'(want.full_res),  int'(got.full_res));
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    victim_table_scoreboard sb;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;
    logic [31:0] key_tag [KEY_POOL];
    logic [15:0] key_set [KEY_POOL];

    fifo_victim_cache_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: decide the stall for the next edge on each falling edge,
    // so stall gaps land on every phase of the pipeline.
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    // Monitor and watchdog: sample both channels on the rising edge. Note the
    // request before checking the response; a response is never for a request
    // that transfers on the same edge, so the order only keeps the queue tidy.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $error("no transfer for %0d cycles, %0d responses outstanding",
                       STALL_LIMIT, sb.pending());
                $display("FAILED: results differ");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive one request. Called just after a falling edge; returns just after
    // the falling edge that follows its transfer, with valid still high so a
    // back-to-back request needs only one assignment in that step.
    task automatic push_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    // Pack the fields, remember inserted keys so later lookups can hit them.
    task automatic send(input action_t act, input logic [31:0] tag,
                        input logic [15:0] set_index, input logic dirty,
                        input logic [1:0] idx);
        req_t r;
        int   k;
        r.action      = act;
        r.tag         = tag;
        r.set_index   = set_index;
        r.dirty_in    = dirty;
        r.entry_index = idx;
        if (act == ACT_INSERT)
        begin
            k          = $urandom_range(KEY_POOL - 1);
            key_tag[k] = tag;
            key_set[k] = set_index;
        end
        push_request(r);
    endtask

    // Hold the request side low until every outstanding response is back.
    // Always advance past a falling edge so valid is not assigned twice
    // in one step.
    task automatic drain_responses();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() > 0);
    endtask

    // Random request: mostly keys already seen so lookups, mark-dirty and
    // duplicate inserts hit live entries; some near misses that share only
    // the tag; the rest fully random so every bit of tag and set toggles.
    task automatic send_random();
        int          pick;
        int          k;
        action_t     act;
        logic [31:0] tag;
        logic [15:0] set_index;
        pick = $urandom_range(99);
        if (pick < 30)
            act = ACT_LOOKUP;
        else if (pick < 58)
            act = ACT_INSERT;
        else if (pick < 78)
            act = ACT_RESTORE;
        else
            act = ACT_MARK_DIRTY;
        k    = $urandom_range(KEY_POOL - 1);
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            tag       = key_tag[k];
            set_index = key_set[k];
        end
        else if (pick < 80)
        begin
            tag       = key_tag[k];
            set_index = 16'($urandom);
        end
        else
        begin
            tag       = $urandom;
            set_index = 16'($urandom);
        end
        send(act, tag, set_index, 1'($urandom_range(1)), 2'($urandom_range(3)));
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b1;
        req_valid     = 1'b0;
        req           = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            key_tag[i] = $urandom;
            key_set[i] = 16'($urandom);
        end
        // Assert reset once every process is waiting on it.
        #1 rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, duplicates, lowest-slot match, set mismatch,
        // eviction of the oldest, restore with age gap closing, restore of a
        // dead slot, and a full drain back to empty.
        send(ACT_LOOKUP,     32'hFFFF_FFFF, 16'hFFFF, 1'b1, 2'd3);
        send(ACT_RESTORE,    32'h0,         16'h0,    1'b0, 2'd0);
        send(ACT_MARK_DIRTY, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 2'd3);
        send(ACT_INSERT,     32'h0,         16'h0,    1'b0, 2'd0);
        send(ACT_INSERT,     32'hFFFF_FFFF, 16'hFFFF, 1'b1, 2'd3);
        send(ACT_INSERT,     32'h0,         16'h0,    1'b1, 2'd1);
        send(ACT_LOOKUP,     32'h0,         16'h0,    1'b0, 2'd0);
        send(ACT_MARK_DIRTY, 32'h0,         16'h0,    1'b0, 2'd0);
        send(ACT_INSERT,     32'h0,         16'hFFFF, 1'b0, 2'd2);
        send(ACT_LOOKUP,     32'h0,         16'h0001, 1'b0, 2'd0);
        send(ACT_LOOKUP,     32'hFFFF_FFFF, 16'hFFFF, 1'b0, 2'd0);
        send(ACT_INSERT,     32'h1234_5678, 16'h5A5A, 1'b0, 2'd0);
        send(ACT_INSERT,     32'h8765_4321, 16'hA5A5, 1'b0, 2'd0);
        send(ACT_RESTORE,    32'h0,         16'h0,    1'b0, 2'd3);
        send(ACT_RESTORE,    32'h0,         16'h0,    1'b0, 2'd3);
        send(ACT_INSERT,     32'hDEAD_BEEF, 16'h8001, 1'b1, 2'd0);
        send(ACT_INSERT,     32'h7FFF_FFFF, 16'h7FFF, 1'b0, 2'd0);
        send(ACT_RESTORE,    32'h0,         16'h0,    1'b0, 2'd0);
        send(ACT_RESTORE,    32'h0,         16'h0,    1'b0, 2'd1);
        send(ACT_RESTORE,    32'h0,         16'h0,    1'b0, 2'd2);
        send(ACT_RESTORE,    32'h0,         16'h0,    1'b0, 2'd3);
        send(ACT_LOOKUP,     32'hDEAD_BEEF, 16'h8001, 1'b0, 2'd0);
        drain_responses();

        // Random: receiver-heavy idling, then sender-heavy, then none.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 28 : 0;
            for (int n = 0; n < 126; n++)
            begin
                send_random();
                if (n == 63)
                    drain_responses();
            end
            drain_responses();
        end

        // Let the pipeline settle, then judge the run.
        repeat (8) @(negedge clk);
        $display("Covered %0d requests over three idling profiles: %0d hits, %0d evictions,",
                 sb.requests, sb.hits, sb.evictions);
        $display("%0d restores of live slots; %0d mismatches, %0d responses missing.",
                 sb.restores, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
